@@ rtl/core/rtt_pkg.sv @@
// shared types, constants and codes for the retransmit timer table
package rtt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int TIME_W      = 32;
	localparam int ENTRY_W     = KEY_W + TIME_W;
	localparam int SLOT_W      = 4;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_ACT,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t               opcode;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] now_time;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic              expired;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

endpackage

@@ rtl/core/rtt_ram.sv @@
// generic single write port ram with registered read
module rtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/rtt_ctrl.sv @@
// sequencer that scans the key/stamp store one entry per cycle and applies each request
module rtt_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  rtt_pkg::req_t              req,
	input  logic [rtt_pkg::TIME_W-1:0] timeout,
	output logic                       res_valid,
	input  logic                       res_ready,
	output rtt_pkg::rsp_t              res
);

	rtt_pkg::state_t state_q, state_d;

	rtt_pkg::op_t                 op_q;
	logic [rtt_pkg::KEY_W-1:0]    key_q;
	logic [rtt_pkg::TIME_W-1:0]   now_q;
	logic [rtt_pkg::TIME_W-1:0]   stamp_q;
	logic [rtt_pkg::CNT_W-1:0]    cnt_q;
	logic [rtt_pkg::CNT_W-1:0]    idx_q;
	logic                         rd_vld_s1;
	logic [rtt_pkg::IDX_W-1:0]    rd_idx_s1;
	logic [rtt_pkg::IDX_W-1:0]    hit_q;
	logic [rtt_pkg::TABLE_DEPTH-1:0] running_q;
	rtt_pkg::rsp_t                res_q;

	logic                         we;
	logic [rtt_pkg::IDX_W-1:0]    waddr;
	logic [rtt_pkg::ENTRY_W-1:0]  wdata;
	logic [rtt_pkg::ENTRY_W-1:0]  rdata;

	logic                         full;
	logic                         accept;
	logic                         add_ok;
	logic                         scan_hit;
	logic                         scan_miss;
	logic                         issue;
	logic [rtt_pkg::TIME_W-1:0]   elapsed;

	rtt_ram #(
		.WIDTH(rtt_pkg::ENTRY_W),
		.DEPTH(rtt_pkg::TABLE_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(idx_q[rtt_pkg::IDX_W-1:0]),
		.rdata(rdata)
	);

	assign full      = (cnt_q == rtt_pkg::CNT_W'(rtt_pkg::TABLE_DEPTH));
	assign scan_hit  = rd_vld_s1 && (rdata[rtt_pkg::TIME_W +: rtt_pkg::KEY_W] == key_q);
	assign scan_miss = !rd_vld_s1 && (idx_q == cnt_q);
	assign issue     = (idx_q < cnt_q);
	assign elapsed   = now_q - stamp_q;
	assign res       = res_q;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		accept    = 1'b0;
		add_ok    = 1'b0;
		we        = 1'b0;
		waddr     = hit_q;
		wdata     = {key_q, now_q};
		case (state_q)
			rtt_pkg::S_IDLE: begin
				req_ready = 1'b1;
				accept    = req_valid;
				waddr     = cnt_q[rtt_pkg::IDX_W-1:0];
				wdata     = {req.key, req.now_time};
				if (req_valid) begin
					if (req.opcode == rtt_pkg::OP_ADD) begin
						add_ok  = !full;
						we      = !full;
						state_d = rtt_pkg::S_DONE;
					end else begin
						state_d = rtt_pkg::S_SCAN;
					end
				end
			end
			rtt_pkg::S_SCAN: begin
				if (scan_hit) begin
					state_d = rtt_pkg::S_ACT;
				end else if (scan_miss) begin
					state_d = rtt_pkg::S_DONE;
				end
			end
			rtt_pkg::S_ACT: begin
				we      = (op_q == rtt_pkg::OP_START);
				state_d = rtt_pkg::S_DONE;
			end
			rtt_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = rtt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rtt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			running_q <= '0;
		end else begin
			if (accept) begin
				idx_q     <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (state_q == rtt_pkg::S_SCAN) begin
				rd_vld_s1 <= issue && !scan_hit;
				if (issue && !scan_hit) begin
					idx_q <= idx_q + rtt_pkg::CNT_W'(1);
				end
			end
			if (add_ok) begin
				cnt_q                                 <= cnt_q + rtt_pkg::CNT_W'(1);
				running_q[cnt_q[rtt_pkg::IDX_W-1:0]] <= 1'b0;
			end
			if (state_q == rtt_pkg::S_ACT) begin
				if (op_q == rtt_pkg::OP_START) begin
					running_q[hit_q] <= 1'b1;
				end else if (op_q == rtt_pkg::OP_STOP) begin
					running_q[hit_q] <= 1'b0;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			key_q <= req.key;
			now_q <= req.now_time;
			if (req.opcode == rtt_pkg::OP_ADD) begin
				res_q.expired <= 1'b0;
				if (full) begin
					res_q.status <= rtt_pkg::ST_FULL;
					res_q.slot   <= '0;
				end else begin
					res_q.status <= rtt_pkg::ST_OK;
					res_q.slot   <= rtt_pkg::SLOT_W'(cnt_q[rtt_pkg::IDX_W-1:0]);
				end
			end
		end
		if (state_q == rtt_pkg::S_SCAN) begin
			rd_idx_s1 <= idx_q[rtt_pkg::IDX_W-1:0];
			if (scan_hit) begin
				hit_q   <= rd_idx_s1;
				stamp_q <= rdata[rtt_pkg::TIME_W-1:0];
			end else if (scan_miss) begin
				res_q.status  <= rtt_pkg::ST_NOT_FOUND;
				res_q.expired <= 1'b0;
				res_q.slot    <= '0;
			end
		end
		if (state_q == rtt_pkg::S_ACT) begin
			res_q.status  <= rtt_pkg::ST_OK;
			res_q.slot    <= rtt_pkg::SLOT_W'(hit_q);
			res_q.expired <= (op_q == rtt_pkg::OP_QUERY) && running_q[hit_q]
				&& (elapsed > timeout);
		end
	end

endmodule

@@ rtl/core/retransmit_timer_table.sv @@
// retransmit timer table: timeout register, sequencer and output register
// add: ram written as the request is taken; response offered from the done state
// start/stop/query: the scan state reads one entry per cycle through the ram read port until
// a key hit or the fill count is reached; a hit passes through the act state to the done state
// one request at a time; the next is taken once the response reaches the output register
// reset clears fill count and running flags, timeout returns to 1000; no clearing pass
module retransmit_timer_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  rtt_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output rtt_pkg::rsp_t              rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rtt_pkg::TIME_W-1:0] cfg_data
);

	logic [rtt_pkg::TIME_W-1:0] timeout_q;
	logic                       rsp_valid_q;
	rtt_pkg::rsp_t              rsp_q;
	logic                       res_valid;
	logic                       res_ready;
	rtt_pkg::rsp_t              res;

	assign cfg_ready = 1'b1;
	assign res_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	rtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.timeout  (timeout_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= rtt_pkg::TIMEOUT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			if (res_valid && res_ready) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

endmodule

@@ tb/retransmit_timer_table_test.sv @@
// testbench for retransmit_timer_table: queued driver, checking monitor and table predictor
`timescale 1ns / 100ps

module retransmit_timer_table_test;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_CYCLES  = 40;
	localparam int LONG_HOLD     = 300;
	localparam int LONG_HOLD_AT  = 400;
	localparam int CALM_TAIL     = 150;

	typedef struct {
		bit                         is_cfg;
		logic [rtt_pkg::TIME_W-1:0] cfg_value;
		rtt_pkg::req_t              payload;
	} table_op_t;

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       req_valid = 1'b0;
	logic                       req_ready;
	rtt_pkg::req_t              req       = '0;
	logic                       rsp_valid;
	logic                       rsp_ready = 1'b0;
	rtt_pkg::rsp_t              rsp;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [rtt_pkg::TIME_W-1:0] cfg_data  = '0;

	table_op_t     pending_ops[$];
	rtt_pkg::rsp_t awaited_rsp[$];

	logic                       timer_valid   [rtt_pkg::TABLE_DEPTH] = '{default: 1'b0};
	logic [rtt_pkg::KEY_W-1:0]  timer_key     [rtt_pkg::TABLE_DEPTH] = '{default: '0};
	logic [rtt_pkg::TIME_W-1:0] timer_stamp   [rtt_pkg::TABLE_DEPTH] = '{default: '0};
	logic                       timer_running [rtt_pkg::TABLE_DEPTH] = '{default: 1'b0};
	logic [rtt_pkg::TIME_W-1:0] model_timeout = rtt_pkg::TIMEOUT_RESET;

	logic [rtt_pkg::KEY_W-1:0]  held_key [rtt_pkg::TABLE_DEPTH];
	logic [rtt_pkg::TIME_W-1:0] start_stamp [logic [rtt_pkg::KEY_W-1:0]];
	logic [rtt_pkg::TIME_W-1:0] gen_timeout = rtt_pkg::TIMEOUT_RESET;
	logic [rtt_pkg::TIME_W-1:0] gen_time;

	int total_reqs     = 0;
	int sent_count     = 0;
	int recv_count     = 0;
	int fail_count     = 0;
	int cycle_count    = 0;
	int gap_left       = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	bit long_hold_done = 1'b0;
	bit next_req_valid;
	bit next_cfg_valid;
	table_op_t     launch;
	rtt_pkg::rsp_t want;

	retransmit_timer_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic rtt_pkg::rsp_t apply_to_table(rtt_pkg::req_t r);
		rtt_pkg::rsp_t              res;
		int                         hit;
		int                         i;
		logic [rtt_pkg::TIME_W-1:0] elapsed;
		res.status  = rtt_pkg::ST_OK;
		res.expired = 1'b0;
		res.slot    = '0;
		hit = -1;
		for (i = rtt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
			if (r.opcode == rtt_pkg::OP_ADD ? !timer_valid[i] :
					(timer_valid[i] && timer_key[i] == r.key))
				hit = i;
		end
		if (hit < 0) begin
			res.status = (r.opcode == rtt_pkg::OP_ADD) ? rtt_pkg::ST_FULL
				: rtt_pkg::ST_NOT_FOUND;
		end else begin
			res.slot = hit[rtt_pkg::SLOT_W-1:0];
			case (r.opcode)
				rtt_pkg::OP_ADD: begin
					timer_valid[hit]   = 1'b1;
					timer_key[hit]     = r.key;
					timer_stamp[hit]   = r.now_time;
					timer_running[hit] = 1'b0;
				end
				rtt_pkg::OP_START: begin
					timer_stamp[hit]   = r.now_time;
					timer_running[hit] = 1'b1;
				end
				rtt_pkg::OP_STOP: begin
					timer_running[hit] = 1'b0;
				end
				default: begin
					elapsed     = r.now_time - timer_stamp[hit];
					res.expired = timer_running[hit] && (elapsed > model_timeout);
				end
			endcase
		end
		return res;
	endfunction

	function automatic bit idle_ok(int n);
		return (n < total_reqs - CALM_TAIL) && ((n / 100) % 4 != 3);
	endfunction

	task automatic queue_req(rtt_pkg::op_t op, logic [rtt_pkg::KEY_W-1:0] key,
			logic [rtt_pkg::TIME_W-1:0] now);
		table_op_t item;
		item.is_cfg    = 1'b0;
		item.cfg_value = '0;
		item.payload   = '{opcode: op, key: key, now_time: now};
		pending_ops.push_back(item);
		total_reqs++;
		if (op == rtt_pkg::OP_START)
			start_stamp[key] = now;
	endtask

	task automatic queue_timeout(logic [rtt_pkg::TIME_W-1:0] value);
		table_op_t item;
		item.is_cfg    = 1'b1;
		item.cfg_value = value;
		item.payload   = '0;
		pending_ops.push_back(item);
		gen_timeout = value;
	endtask

	task automatic queue_random_phase(int n);
		int                         i;
		int                         pick;
		logic [rtt_pkg::KEY_W-1:0]  k;
		logic [rtt_pkg::TIME_W-1:0] t;
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			k = held_key[$urandom_range(0, rtt_pkg::TABLE_DEPTH - 1)];
			gen_time += $urandom_range(0, 3000);
			t = ($urandom_range(0, 3) == 0) ? $urandom() : gen_time;
			if (pick < 6) begin
				queue_req(rtt_pkg::OP_ADD, $urandom(), $urandom());
			end else if (pick < 14) begin
				queue_req(rtt_pkg::op_t'($urandom_range(1, 3)), $urandom(), t);
			end else if (pick < 40) begin
				queue_req(rtt_pkg::OP_START, k, t);
			end else if (pick < 52) begin
				queue_req(rtt_pkg::OP_STOP, k, t);
			end else begin
				if (start_stamp.exists(k) && $urandom_range(0, 2) != 0)
					t = start_stamp[k] + gen_timeout + 32'($urandom_range(0, 3)) - 32'd1;
				queue_req(rtt_pkg::OP_QUERY, k, t);
			end
		end
	endtask

	initial begin
		int i;
		gen_time = $urandom();
		held_key[0] = 32'h0000_0000;
		held_key[1] = 32'hFFFF_FFFF;
		held_key[2] = 32'h0000_0000;
		for (i = 3; i < rtt_pkg::TABLE_DEPTH; i++)
			held_key[i] = $urandom();
		held_key[7]  = held_key[4];
		held_key[12] = 32'h0000_0000;

		queue_req(rtt_pkg::OP_QUERY, 32'd5, 32'h0000_0000);
		queue_req(rtt_pkg::OP_ADD, held_key[0], 32'hFFFF_FFF0);
		queue_req(rtt_pkg::OP_ADD, held_key[1], 32'h0000_0000);
		queue_req(rtt_pkg::OP_ADD, held_key[2], 32'h0000_0064);
		queue_req(rtt_pkg::OP_START, 32'h0000_0000, 32'hFFFF_FFF8);
		queue_req(rtt_pkg::OP_QUERY, 32'h0000_0000, 32'h0000_03E0);
		queue_req(rtt_pkg::OP_QUERY, 32'h0000_0000, 32'h0000_03E1);
		queue_req(rtt_pkg::OP_STOP, 32'h0000_0000, 32'h0000_0000);
		queue_req(rtt_pkg::OP_QUERY, 32'h0000_0000, 32'h0000_03E1);
		queue_req(rtt_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'h0000_03E1);
		queue_req(rtt_pkg::OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_req(rtt_pkg::OP_STOP, 32'd7, 32'h1234_5678);
		queue_req(rtt_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'h0000_03E9);
		for (i = 3; i < rtt_pkg::TABLE_DEPTH; i++)
			queue_req(rtt_pkg::OP_ADD, held_key[i], $urandom());
		queue_req(rtt_pkg::OP_ADD, $urandom(), $urandom());

		queue_random_phase(150);
		queue_timeout(32'h0000_0000);
		queue_random_phase(180);
		queue_timeout(32'hFFFF_FFFF);
		queue_random_phase(180);
		queue_timeout(32'h0000_0001);
		queue_random_phase(160);
		queue_timeout($urandom());
		queue_random_phase(160);
		queue_timeout(32'hFFFF_FFFE);
		queue_random_phase(160);
		queue_timeout($urandom_range(100, 5000));
		queue_random_phase(160);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_ops.size() != 0 || req_valid || cfg_valid || awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// request and register write driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				awaited_rsp.push_back(apply_to_table(req));
				sent_count++;
			end
			if (cfg_valid && cfg_ready)
				model_timeout = cfg_data;
			next_req_valid = req_valid && !req_ready;
			next_cfg_valid = cfg_valid && !cfg_ready;
			quiet_cycles = (awaited_rsp.size() == 0 && !next_req_valid) ? quiet_cycles + 1 : 0;
			if (!next_req_valid && !next_cfg_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ops.size() != 0) begin
					if (!pending_ops[0].is_cfg) begin
						launch = pending_ops.pop_front();
						req <= launch.payload;
						next_req_valid = 1'b1;
						if (idle_ok(sent_count) && $urandom_range(0, 3) == 0)
							gap_left = $urandom_range(1, 3);
					end else if (quiet_cycles >= SETTLE_CYCLES) begin
						launch = pending_ops.pop_front();
						cfg_data <= launch.cfg_value;
						next_cfg_valid = 1'b1;
					end
				end
			end
			req_valid <= next_req_valid;
			cfg_valid <= next_cfg_valid;
		end
	end

	// response monitor and backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				recv_count++;
				if (awaited_rsp.size() == 0) begin
					$error("unexpected response: status %0d expired %0d slot %0d",
						rsp.status, rsp.expired, rsp.slot);
					fail_count++;
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						fail_count++;
					end
					if (rsp.expired !== want.expired) begin
						$error("expired: expected %0d, actual %0d", want.expired, rsp.expired);
						fail_count++;
					end
					if (rsp.slot !== want.slot) begin
						$error("slot: expected %0d, actual %0d", want.slot, rsp.slot);
						fail_count++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (!long_hold_done && recv_count >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				rsp_ready <= 1'b0;
			end else if (idle_ok(recv_count) && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(0, 2);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule

@@ sim.f @@
rtl/core/rtt_pkg.sv
rtl/core/rtt_ram.sv
rtl/core/rtt_ctrl.sv
rtl/core/retransmit_timer_table.sv
tb/retransmit_timer_table_test.sv
